// ===== sv/u8d_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and decode functions for the UTF-8 stream decoder.
// No dependencies; used by the top level, front end, queue and emitter.
package u8d_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0]  LIMIT_ONE_BYTE   = 8'h80;
    localparam logic [7:0]  LIMIT_TWO_BYTE   = 8'hE0;
    localparam logic [7:0]  LIMIT_THREE_BYTE = 8'hF0;
    localparam logic [7:0]  MASK_TWO_BYTE    = 8'h1F;
    localparam logic [7:0]  MASK_THREE_BYTE  = 8'h0F;
    localparam logic [7:0]  MASK_FOUR_BYTE   = 8'h07;
    localparam logic [7:0]  MASK_CONT        = 8'h3F;
    localparam logic [20:0] REPLACEMENT_CP   = 21'h00FFFD;

    typedef struct packed {
        logic [20:0] code_point;
        logic        substituted;
        logic        last_of_run;
    } result_t;

    // Up to three results produced by one accepted byte; count is 1 to 3.
    typedef struct packed {
        result_t [2:0] res;
        logic [1:0]    count;
    } job_t;

    typedef struct packed {
        logic [20:0] code;
        logic        sub;
        logic [2:0]  used;
    } dec_t;

    typedef struct packed {
        logic       full;
        logic       empty;
    } queue_status_t;

    function automatic logic [1:0] lead_extra(input logic [7:0] lead);
        logic [1:0] extra;
        if (lead < LIMIT_ONE_BYTE)
            extra = 2'd0;
        else if (lead < LIMIT_TWO_BYTE)
            extra = 2'd1;
        else if (lead < LIMIT_THREE_BYTE)
            extra = 2'd2;
        else
            extra = 2'd3;
        return extra;
    endfunction

    // Decodes the sequence whose lead sits in b[0], given how many bytes are available.
    function automatic dec_t decode_seq(input logic [3:0][7:0] b, input logic [2:0] avail);
        dec_t       d;
        logic [1:0] extra;
        logic [7:0] c1;
        logic [7:0] c2;
        logic [7:0] c3;
        logic [7:0] l2;
        logic [7:0] l3;
        logic [7:0] l4;
        extra = lead_extra(b[0]);
        c1 = b[1] & MASK_CONT;
        c2 = b[2] & MASK_CONT;
        c3 = b[3] & MASK_CONT;
        l2 = b[0] & MASK_TWO_BYTE;
        l3 = b[0] & MASK_THREE_BYTE;
        l4 = b[0] & MASK_FOUR_BYTE;
        unique case (extra)
            2'd0: d.code = {13'd0, b[0]};
            2'd1: d.code = {10'd0, l2[4:0], c1[5:0]};
            2'd2: d.code = {5'd0, l3[3:0], c1[5:0], c2[5:0]};
            default: d.code = {l4[2:0], c1[5:0], c2[5:0], c3[5:0]};
        endcase
        d.used = {1'b0, extra} + 3'd1;
        d.sub  = 1'b0;
        if (d.used > avail)
        begin
            d.code = REPLACEMENT_CP;
            d.sub  = 1'b1;
            d.used = 3'd1;
        end
        return d;
    endfunction

endpackage

// ===== sv/u8d_byte_if.sv =====
`timescale 1ns / 1ps
// Input channel of the decoder: one raw byte per request with an end flag.
// No dependencies.
interface u8d_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       end_of_string;

    modport source (output valid, output byte_in, output end_of_string, input ready);
    modport sink   (input valid, input byte_in, input end_of_string, output ready);
endinterface

// ===== sv/u8d_cp_if.sv =====
`timescale 1ns / 1ps
// Output channel of the decoder: one code point per request.
// No dependencies.
interface u8d_cp_if;
    logic        valid;
    logic        ready;
    logic [20:0] code_point;
    logic        substituted;
    logic        last_of_run;

    modport source (output valid, output code_point, output substituted,
                    output last_of_run, input ready);
    modport sink   (input valid, input code_point, input substituted,
                    input last_of_run, output ready);
endinterface

// ===== sv/utf8_stream_decoder.sv =====
`timescale 1ns / 1ps
// UTF-8 stream decoder. Takes one byte per cycle while the job queue is not
// full and emits one code point per complete sequence, through a queue entry,
// the job register and the output register. Bytes that do not finish a sequence
// cause no result. A byte marked end_of_string flushes the open sequence: a
// truncated lead gives 0xFFFD with substituted set and the bytes after it are
// decoded again as leads, so that byte yields up to three results, which the
// emitter sends one per cycle while out_ready is high; the job queue (QUEUE_DEPTH
// entries) lets input continue while such a burst drains. Sustained rate is one
// byte per cycle while out_ready is high, less when such a burst fills the queue.
// Depends on u8d_pkg, u8d_byte_if, u8d_cp_if, u8d_front, u8d_queue, u8d_emitter.
module utf8_stream_decoder #(
    parameter int QUEUE_DEPTH = u8d_pkg::QUEUE_DEPTH
) (
    input  logic      clk,
    input  logic      rst_n,
    u8d_byte_if.sink  byte_chan,
    u8d_cp_if.source  cp_chan
);

    logic                   accept;
    logic                   push;
    logic                   pop;
    logic [1:0]             held_count;
    u8d_pkg::job_t          push_job;
    u8d_pkg::job_t          head_job;
    u8d_pkg::queue_status_t q_status;
    u8d_pkg::result_t       out_result;

    assign byte_chan.ready = !q_status.full;
    assign accept          = byte_chan.valid && byte_chan.ready;

    u8d_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .byte_in       (byte_chan.byte_in),
        .end_of_string (byte_chan.end_of_string),
        .push          (push),
        .job           (push_job),
        .held_count    (held_count)
    );

    u8d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .status   (q_status)
    );

    u8d_emitter u_emitter (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (q_status.empty),
        .head_job    (head_job),
        .pop         (pop),
        .out_valid   (cp_chan.valid),
        .out_ready   (cp_chan.ready),
        .out_result  (out_result)
    );

    assign cp_chan.code_point  = out_result.code_point;
    assign cp_chan.substituted = out_result.substituted;
    assign cp_chan.last_of_run = out_result.last_of_run;

    // A job is never pushed into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n) push |-> !q_status.full)
        else $error("job pushed into a full queue");

    // A substituted result always carries the replacement character.
    assert property (@(posedge clk) disable iff (!rst_n)
        cp_chan.valid && cp_chan.substituted |-> cp_chan.code_point == u8d_pkg::REPLACEMENT_CP)
        else $error("substituted result without replacement character");

    // The end of a string always leaves no open sequence behind.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && byte_chan.end_of_string |=> held_count == 2'd0)
        else $error("bytes still held after end of string");

endmodule

// ===== sv/u8d_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts bytes, keeps the open sequence and builds result jobs.
// Depends on u8d_pkg.
module u8d_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  logic [7:0]      byte_in,
    input  logic            end_of_string,
    output logic            push,
    output u8d_pkg::job_t   job,
    output logic [1:0]      held_count
);

    logic [2:0][7:0]   held_reg;
    logic [1:0]        count_reg;
    logic [1:0]        count_next;
    logic [3:0][7:0]   buf_b;
    logic [3:0][7:0]   sh1;
    logic [3:0][7:0]   sh2;
    logic [2:0]        n;
    logic [2:0]        p1;
    logic [2:0]        p2;
    logic              have1;
    logic              have2;
    u8d_pkg::dec_t     d0;
    u8d_pkg::dec_t     d1;
    u8d_pkg::dec_t     d2;

    // Held bytes first, then the new byte; entries past the count are unused.
    always_comb
    begin
        buf_b[0] = (count_reg > 2'd0) ? held_reg[0] : byte_in;
        buf_b[1] = (count_reg > 2'd1) ? held_reg[1] :
                   ((count_reg == 2'd1) ? byte_in : 8'd0);
        buf_b[2] = (count_reg > 2'd2) ? held_reg[2] :
                   ((count_reg == 2'd2) ? byte_in : 8'd0);
        buf_b[3] = (count_reg == 2'd3) ? byte_in : 8'd0;
    end

    assign n     = {1'b0, count_reg} + 3'd1;
    assign d0    = u8d_pkg::decode_seq(buf_b, n);
    assign p1    = d0.used;
    assign have1 = n > p1;
    assign sh1   = buf_b >> {p1, 3'b000};
    assign d1    = u8d_pkg::decode_seq(sh1, n - p1);
    assign p2    = p1 + d1.used;
    assign have2 = have1 && (n > p2);
    assign sh2   = buf_b >> {p2, 3'b000};
    assign d2    = u8d_pkg::decode_seq(sh2, n - p2);

    always_comb
    begin
        job.res[0] = '{code_point: d0.code, substituted: d0.sub, last_of_run: 1'b1};
        job.res[1] = '{code_point: d1.code, substituted: d1.sub, last_of_run: !have2};
        job.res[2] = '{code_point: d2.code, substituted: d2.sub, last_of_run: 1'b1};
        job.count  = 2'd1;
        if (end_of_string)
        begin
            job.res[0].last_of_run = !have1;
            job.count = 2'd1 + {1'b0, have1} + {1'b0, have2};
        end
    end

    assign push = accept && (end_of_string || !d0.sub);

    always_comb
    begin
        count_next = count_reg;
        if (accept)
        begin
            if (end_of_string || !d0.sub)
                count_next = 2'd0;
            else
                count_next = count_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_next;
    end

    // An incomplete sequence never holds more than three bytes.
    always_ff @(posedge clk)
    begin
        if (accept && !end_of_string && d0.sub)
            held_reg[count_reg] <= byte_in;
    end

    assign held_count = count_reg;

endmodule

// ===== sv/u8d_queue.sv =====
`timescale 1ns / 1ps
// Small job queue between the front end and the emitter.
// Depends on u8d_pkg.
module u8d_queue #(
    parameter int DEPTH = u8d_pkg::QUEUE_DEPTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  u8d_pkg::job_t          push_job,
    input  logic                   pop,
    output u8d_pkg::job_t          head_job,
    output u8d_pkg::queue_status_t status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    u8d_pkg::job_t    mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head_job     = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

endmodule

// ===== sv/u8d_emitter.sv =====
`timescale 1ns / 1ps
// Back end: walks the results of each job and drives the output register.
// Depends on u8d_pkg.
module u8d_emitter (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               queue_empty,
    input  u8d_pkg::job_t      head_job,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output u8d_pkg::result_t   out_result
);

    u8d_pkg::job_t    job_reg;
    logic             job_valid_reg;
    logic [1:0]       idx_reg;
    logic             out_valid_reg;
    u8d_pkg::result_t out_reg;
    logic             out_load;
    logic             emit;
    logic             job_done;

    assign out_load = !out_valid_reg || out_ready;
    assign emit     = job_valid_reg && out_load;
    assign job_done = emit && (idx_reg == job_reg.count - 2'd1);
    assign pop      = !queue_empty && (!job_valid_reg || job_done);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                job_valid_reg <= 1'b1;
                idx_reg       <= 2'd0;
            end
            else if (job_done)
                job_valid_reg <= 1'b0;
            else if (emit)
                idx_reg <= idx_reg + 2'd1;
            if (out_load)
                out_valid_reg <= job_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            job_reg <= head_job;
        if (emit)
            out_reg <= job_reg.res[idx_reg];
    end

    assign out_valid  = out_valid_reg;
    assign out_result = out_reg;

endmodule
